>>> sv/b64d_pkg.sv
package b64d_pkg;

   // character codes with a meaning of their own
   localparam logic [7:0] PAD_CHAR   = 8'h3D;
   localparam logic [7:0] PLUS_CHAR  = 8'h2B;
   localparam logic [7:0] SLASH_CHAR = 8'h2F;

   // alphabet range bounds
   localparam logic [7:0] UPPER_A = 8'h41;
   localparam logic [7:0] UPPER_Z = 8'h5A;
   localparam logic [7:0] LOWER_A = 8'h61;
   localparam logic [7:0] LOWER_Z = 8'h7A;
   localparam logic [7:0] DIGIT_0 = 8'h30;
   localparam logic [7:0] DIGIT_9 = 8'h39;

   // sextet offsets of the lower-case and digit ranges, and the plus and slash sextets
   localparam logic [5:0] LOWER_BASE = 6'd26;
   localparam logic [5:0] DIGIT_BASE = 6'd52;
   localparam logic [5:0] PLUS_SEXTET  = 6'd62;
   localparam logic [5:0] SLASH_SEXTET = 6'd63;

   // position of a character within its four-character group
   typedef enum logic [1:0] {
      POS_FIRST  = 2'd0,
      POS_SECOND = 2'd1,
      POS_THIRD  = 2'd2,
      POS_FOURTH = 2'd3
   } pos_type;

   // one input character
   typedef struct packed {
      logic [7:0] char_in;
      logic       last_char;
   } req_type;

   // one decoded result
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_string;
   } rsp_type;

   // character to 6-bit value, anything outside the alphabet gives zero
   function automatic logic [5:0] sextet_of(input logic [7:0] c);
      logic [7:0] diff;
      diff = 8'd0;
      if (c >= UPPER_A && c <= UPPER_Z) begin
         diff = c - UPPER_A;
         return diff[5:0];
      end
      if (c >= LOWER_A && c <= LOWER_Z) begin
         diff = c - LOWER_A;
         return diff[5:0] + LOWER_BASE;
      end
      if (c >= DIGIT_0 && c <= DIGIT_9) begin
         diff = c - DIGIT_0;
         return diff[5:0] + DIGIT_BASE;
      end
      if (c == PLUS_CHAR) begin
         return PLUS_SEXTET;
      end
      if (c == SLASH_CHAR) begin
         return SLASH_SEXTET;
      end
      return 6'd0;
   endfunction

endpackage

>>> sv/b64d_in_stage.sv
module b64d_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  b64d_pkg::req_type req_data,
   output logic              item_valid,
   output b64d_pkg::req_type item_data,
   input  logic              item_take
);
   import b64d_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    load;

   // hold off the sender only while the held item cannot move on
   assign req_stall = valid_ff && !item_take;
   assign load      = req_valid && !req_stall;

   // input register occupancy
   always_comb begin
      valid_in = valid_ff;
      if (item_take) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register, loaded on each accepted transfer
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

>>> sv/b64d_core.sv
module b64d_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  b64d_pkg::req_type item_data,
   output logic              item_take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b64d_pkg::rsp_type rsp_data
);
   import b64d_pkg::*;

   pos_type    pos_ff;
   pos_type    pos_in;
   logic [5:0] prev_ff;
   logic [5:0] prev_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   rsp_type    rsp_data_ff;
   rsp_type    result;
   logic       has_result;
   logic       out_free;
   logic [5:0] sextet;
   logic       is_pad;

   // result register can take a new value when empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign item_take = item_valid && out_free;

   assign sextet = sextet_of(item_data.char_in);
   assign is_pad = (item_data.char_in == PAD_CHAR);

   // byte assembly from the previous and current sextet
   always_comb begin
      result.data_byte     = 8'd0;
      result.byte_valid    = 1'b0;
      result.end_of_string = item_data.last_char;
      unique case (pos_ff)
         POS_FIRST: begin
            if (item_data.last_char) begin
               result.data_byte  = {sextet, 2'b00};
               result.byte_valid = 1'b1;
            end
         end
         POS_SECOND: begin
            result.data_byte  = {prev_ff, sextet[5:4]};
            result.byte_valid = 1'b1;
         end
         POS_THIRD: begin
            if (!is_pad) begin
               result.data_byte  = {prev_ff[3:0], sextet[5:2]};
               result.byte_valid = 1'b1;
            end
         end
         POS_FOURTH: begin
            if (!is_pad) begin
               result.data_byte  = {prev_ff[1:0], sextet};
               result.byte_valid = 1'b1;
            end
         end
         default: begin
            result.data_byte  = 8'd0;
            result.byte_valid = 1'b0;
         end
      endcase
   end

   assign has_result = result.byte_valid || item_data.last_char;

   // group tracking, back to the start after the last character
   always_comb begin
      pos_in  = pos_ff;
      prev_in = prev_ff;
      if (item_take) begin
         if (item_data.last_char) begin
            pos_in  = POS_FIRST;
            prev_in = 6'd0;
         end else begin
            pos_in  = pos_type'(pos_ff + 2'd1);
            prev_in = sextet;
         end
      end
   end

   // result register occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = item_take && has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_FIRST;
         prev_ff      <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded only when a result is produced
   always_ff @(posedge clock) begin
      if (item_take && has_result) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/base64_stream_decoder.sv
// Streaming base64 decoder, one character per transfer.
// Input channel req_: req_data carries a character and a last-character flag.
// Result channel rsp_: rsp_data carries a decoded byte, its valid flag and an
// end-of-string flag. A result appears once per full byte, and once more for
// the last character even when no byte is due (byte_valid low then).
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low.
// A character's result reaches rsp_ through the input register, then the
// result register. One character per cycle while the receiver does not
// stall; the decode between the two registers is a small range lookup and
// a shift.
// When the receiver stalls, the result register holds its value; req_stall
// rises in the same cycle if the input register holds a character, or as
// soon as the next transfer fills it; no transfer is lost.
// Reset empties both registers and restarts the group at its first position
// with a zero previous value. After the last character the group restarts.
module base64_stream_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  b64d_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b64d_pkg::rsp_type rsp_data
);
   import b64d_pkg::*;

   logic    item_valid;
   logic    item_take;
   req_type item_data;

   // input register
   b64d_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_take  (item_take)
   );

   // decode and result register
   b64d_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_take  (item_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
